/* sv/esbt_pkg.sv */
// Shared types, codes and helper functions of the entity slot bitmap table.
package esbt_pkg;

  localparam int WORD_BITS = 64;

  typedef enum logic [2:0] {
    OP_CREATE      = 3'd0,
    OP_DESTROY     = 3'd1,
    OP_SET_ENABLED = 3'd2,
    OP_ADD         = 3'd3,
    OP_REMOVE      = 3'd4,
    OP_QUERY       = 3'd5,
    OP_FIRST       = 3'd6,
    OP_NEXT        = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_ALIVE    = 3'd1,
    ST_NO_FREE      = 3'd2,
    ST_UNREGISTERED = 3'd3,
    ST_PRESENT      = 3'd4,
    ST_ABSENT       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_TYPES       = 2'd0,
    REG_AUTO_TYPE   = 2'd1,
    REG_AUTO_ENABLE = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_EVAL, S_SCAN, S_CWR, S_ARD, S_AWR,
    S_DRD, S_DWR, S_DAE, S_MRD, S_MEV, S_REP, S_REPD, S_OUT
  } state_t;

  // Position of the lowest set bit; only used on a non-zero word.
  function automatic logic [5:0] lowest_bit(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

/* sv/esbt_ram.sv */
// Generic synchronous RAM with one write port and one registered read port.
module esbt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* sv/entity_slot_bitmap_table_unit.sv */
// Entity slot bitmap table: top level with control sequencer and bitmap memories.
//
// One command enters on the s_ channel (op in s_tuser, operands in s_tdata) and
// exactly one result leaves on the m_ channel, in order. Commands are worked one
// at a time; s_tready is high only while the sequencer is idle. A finished result
// waits in the output register, so the next command is taken while the receiver
// stalls; a second result waits inside the sequencer until the register frees.
// Destroy reads and writes back each type's membership word in turn; add and
// remove read the membership word unless refused before that read; create,
// first and next run a word scan, which reads one 64-bit bitmap word per cycle
// from the memory port.
// The alive and enabled bitmaps share one 128-bit wide memory; the membership
// bitmaps live in a second memory of NUM_TYPES*SLOT_COUNT/64 words.
// After reset a clearing pass writes zero to every word of both memories,
// during which no command is taken. Configuration writes on cfg_we take effect
// at the next edge; the user must make them only while no command is in flight,
// and the block itself does not enforce this.
module entity_slot_bitmap_table_unit #(
  parameter int SLOT_COUNT = 4096,
  parameter int NUM_TYPES  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: entity[11:0], type_index[17:12], enable_value[18], zero fill
  input  logic [23:0] s_tdata,
  // s_tuser: op[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: status[2:0], entity_out[14:3], found[15], is_alive[16],
  // is_enabled[17], has_type[18], live_count[31:19]
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int WORDS  = (SLOT_COUNT + esbt_pkg::WORD_BITS - 1) / esbt_pkg::WORD_BITS;
  localparam int WAW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int MDEPTH = NUM_TYPES * WORDS;
  localparam int MAW    = MDEPTH > 1 ? $clog2(MDEPTH) : 1;
  localparam int WCW    = $clog2(WORDS + 1);
  localparam int TIW    = NUM_TYPES > 1 ? $clog2(NUM_TYPES) : 1;
  localparam int CNW    = $clog2(SLOT_COUNT + 1);

  esbt_pkg::state_t  state, state_next;
  logic [63:0]       types_reg;
  logic [5:0]        auto_type;
  logic              auto_en;

  esbt_pkg::op_t     op;
  logic [11:0]       ent;
  logic [5:0]        ty;
  logic              en_val;
  logic [WAW-1:0]    sw;
  logic [5:0]        sb;
  logic [127:0]      ae_word;
  logic [TIW-1:0]    tcnt;
  logic [MAW-1:0]    clr_cnt;
  logic [WCW-1:0]    scan_rd;
  logic              dv;
  logic [WAW-1:0]    dword;
  logic [WAW-1:0]    first_word;
  logic [5:0]        start_bit;
  logic              scan_inv;
  logic [CNW-1:0]    live_cnt;

  esbt_pkg::status_t res_status;
  logic [11:0]       res_eout;
  logic              res_found, res_alive, res_en, res_has;

  logic              ae_we, m_we;
  logic [WAW-1:0]    ae_waddr, ae_raddr;
  logic [MAW-1:0]    m_waddr, m_raddr;
  logic [127:0]      ae_wdata, ae_rdata;
  logic [63:0]       m_wdata, m_rdata;

  logic [5:0]        tysel;
  logic              tok, auto_ok, live, present;
  logic [63:0]       bitm, ae_en_part, scan_base, scan_v;
  logic              scan_hit, scan_pos_ok, scan_more, scan_miss;
  logic [5:0]        scan_lsb;
  int                scan_pos;
  logic [12:0]       start;
  logic              start_ok, ent_ok, out_load;

  function automatic logic type_ok(input logic [5:0] t, input logic [63:0] regs);
    return (int'(t) < NUM_TYPES) && regs[t];
  endfunction

  function automatic logic [MAW-1:0] maddr(input int t, input logic [WAW-1:0] w);
    return MAW'(t * WORDS + int'(w));
  endfunction

  esbt_ram #(.WIDTH(128), .DEPTH(WORDS)) u_ae_ram (
    .clk(clk), .we(ae_we), .waddr(ae_waddr), .wdata(ae_wdata),
    .raddr(ae_raddr), .rdata(ae_rdata)
  );

  esbt_ram #(.WIDTH(64), .DEPTH(MDEPTH)) u_mem_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  assign s_tready   = (state == esbt_pkg::S_IDLE);
  assign tysel      = (int'(ty) < NUM_TYPES) ? ty : 6'd0;
  assign tok        = type_ok(ty, types_reg);
  assign auto_ok    = auto_en && type_ok(auto_type, types_reg);
  assign bitm       = 64'd1 << sb;
  assign ae_en_part = ae_rdata[127:64];
  assign live       = ae_rdata[sb];
  assign present    = m_rdata[sb];

  // The scan examines the word read in the previous cycle; the start word is
  // masked below the start position.
  assign scan_base   = scan_inv ? ~ae_rdata[63:0] : m_rdata;
  assign scan_v      = (dword == first_word) ? (scan_base & (~64'd0 << start_bit)) : scan_base;
  assign scan_hit    = dv && (scan_v != 64'd0);
  assign scan_lsb    = esbt_pkg::lowest_bit(scan_v);
  assign scan_pos    = int'(dword) * esbt_pkg::WORD_BITS + int'(scan_lsb);
  assign scan_pos_ok = scan_pos < SLOT_COUNT;
  assign scan_more   = int'(scan_rd) < WORDS;
  assign scan_miss   = scan_hit ? !scan_pos_ok : !scan_more;

  assign start    = (op == esbt_pkg::OP_NEXT) ? (13'(ent) + 13'd1) : 13'd0;
  assign start_ok = int'(start) < SLOT_COUNT;
  assign ent_ok   = int'(ent) < SLOT_COUNT;
  assign out_load = (state == esbt_pkg::S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) state <= esbt_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ae_we      = 1'b0;
    ae_waddr   = sw;
    ae_wdata   = ae_word;
    ae_raddr   = (state == esbt_pkg::S_SCAN) ? WAW'(scan_rd) : sw;
    m_we       = 1'b0;
    m_waddr    = maddr(int'(tysel), sw);
    m_wdata    = m_rdata;
    m_raddr    = maddr(int'(tysel), sw);
    case (state)
      esbt_pkg::S_CLEAR: begin
        m_we     = 1'b1;
        m_waddr  = clr_cnt;
        m_wdata  = 64'd0;
        ae_we    = int'(clr_cnt) < WORDS;
        ae_waddr = WAW'(clr_cnt);
        ae_wdata = 128'd0;
        if (int'(clr_cnt) == MDEPTH - 1) state_next = esbt_pkg::S_IDLE;
      end
      esbt_pkg::S_IDLE: begin
        if (s_tvalid) state_next = esbt_pkg::S_LOOK;
      end
      esbt_pkg::S_LOOK: begin
        case (op)
          esbt_pkg::OP_CREATE: state_next = esbt_pkg::S_SCAN;
          esbt_pkg::OP_FIRST, esbt_pkg::OP_NEXT: begin
            state_next = (tok && start_ok) ? esbt_pkg::S_SCAN : esbt_pkg::S_OUT;
          end
          default: state_next = ent_ok ? esbt_pkg::S_EVAL : esbt_pkg::S_OUT;
        endcase
      end
      esbt_pkg::S_EVAL: begin
        state_next = esbt_pkg::S_REP;
        if (live) begin
          case (op)
            esbt_pkg::OP_DESTROY: state_next = esbt_pkg::S_DRD;
            esbt_pkg::OP_ADD, esbt_pkg::OP_REMOVE: begin
              if (tok) state_next = esbt_pkg::S_MRD;
            end
            esbt_pkg::OP_SET_ENABLED: begin
              ae_we    = 1'b1;
              ae_wdata = en_val ? (ae_rdata | {bitm, 64'd0}) : (ae_rdata & ~{bitm, 64'd0});
            end
            default: ;
          endcase
        end
      end
      esbt_pkg::S_SCAN: begin
        m_raddr = maddr(int'(tysel), WAW'(scan_rd));
        if (scan_miss) begin
          state_next = esbt_pkg::S_OUT;
        end else if (scan_hit) begin
          state_next = (op == esbt_pkg::OP_CREATE) ? esbt_pkg::S_CWR : esbt_pkg::S_REP;
        end
      end
      esbt_pkg::S_CWR: begin
        ae_we      = 1'b1;
        ae_wdata   = ae_word | {bitm, bitm};
        state_next = auto_ok ? esbt_pkg::S_ARD : esbt_pkg::S_REP;
      end
      esbt_pkg::S_ARD: begin
        m_raddr    = maddr(int'(auto_type), sw);
        state_next = esbt_pkg::S_AWR;
      end
      esbt_pkg::S_AWR: begin
        m_we       = 1'b1;
        m_waddr    = maddr(int'(auto_type), sw);
        m_wdata    = m_rdata | bitm;
        state_next = esbt_pkg::S_REP;
      end
      esbt_pkg::S_DRD: begin
        m_raddr    = maddr(int'(tcnt), sw);
        state_next = esbt_pkg::S_DWR;
      end
      esbt_pkg::S_DWR: begin
        m_we    = 1'b1;
        m_waddr = maddr(int'(tcnt), sw);
        m_wdata = m_rdata & ~bitm;
        state_next = (int'(tcnt) == NUM_TYPES - 1) ? esbt_pkg::S_DAE : esbt_pkg::S_DRD;
      end
      esbt_pkg::S_DAE: begin
        ae_we      = 1'b1;
        ae_wdata   = ae_word & ~{bitm, bitm};
        state_next = esbt_pkg::S_REP;
      end
      esbt_pkg::S_MRD: state_next = esbt_pkg::S_MEV;
      esbt_pkg::S_MEV: begin
        if (op == esbt_pkg::OP_ADD && !present) begin
          m_we    = 1'b1;
          m_wdata = m_rdata | bitm;
        end else if (op == esbt_pkg::OP_REMOVE && present) begin
          m_we    = 1'b1;
          m_wdata = m_rdata & ~bitm;
        end
        state_next = esbt_pkg::S_REP;
      end
      esbt_pkg::S_REP:  state_next = esbt_pkg::S_REPD;
      esbt_pkg::S_REPD: state_next = esbt_pkg::S_OUT;
      esbt_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) state_next = esbt_pkg::S_IDLE;
      end
      default: state_next = esbt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      types_reg <= 64'd7;
      auto_type <= 6'd0;
      auto_en   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        esbt_pkg::REG_TYPES:       types_reg <= cfg_data;
        esbt_pkg::REG_AUTO_TYPE:   auto_type <= cfg_data[5:0];
        esbt_pkg::REG_AUTO_ENABLE: auto_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      live_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == esbt_pkg::S_CLEAR) clr_cnt <= clr_cnt + MAW'(1);
      if (state == esbt_pkg::S_CWR) live_cnt <= live_cnt + CNW'(1);
      if (state == esbt_pkg::S_DAE && live_cnt != '0) live_cnt <= live_cnt - CNW'(1);
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      esbt_pkg::S_IDLE: begin
        if (s_tvalid) begin
          op         <= esbt_pkg::op_t'(s_tuser);
          ent        <= s_tdata[11:0];
          ty         <= s_tdata[17:12];
          en_val     <= s_tdata[18];
          sw         <= WAW'(s_tdata[11:6]);
          sb         <= s_tdata[5:0];
          res_status <= esbt_pkg::ST_OK;
          res_eout   <= 12'd0;
          res_found  <= 1'b0;
          res_alive  <= 1'b0;
          res_en     <= 1'b0;
          res_has    <= 1'b0;
        end
      end
      esbt_pkg::S_LOOK: begin
        scan_rd    <= WCW'(start >> 6);
        first_word <= WAW'(start >> 6);
        start_bit  <= start[5:0];
        scan_inv   <= (op == esbt_pkg::OP_CREATE);
        dv         <= 1'b0;
        case (op)
          esbt_pkg::OP_CREATE: ;
          esbt_pkg::OP_FIRST, esbt_pkg::OP_NEXT: begin
            if (!tok)           res_status <= esbt_pkg::ST_UNREGISTERED;
            else if (!start_ok) res_status <= esbt_pkg::ST_ABSENT;
          end
          default: begin
            if (!ent_ok) res_status <= esbt_pkg::ST_NOT_ALIVE;
          end
        endcase
      end
      esbt_pkg::S_EVAL: begin
        ae_word <= ae_rdata;
        tcnt    <= '0;
        if (!live) begin
          res_status <= esbt_pkg::ST_NOT_ALIVE;
        end else if (op == esbt_pkg::OP_ADD || op == esbt_pkg::OP_REMOVE ||
                     op == esbt_pkg::OP_QUERY) begin
          if (!tok) res_status <= esbt_pkg::ST_UNREGISTERED;
        end
      end
      esbt_pkg::S_SCAN: begin
        if (scan_miss) begin
          res_status <= (op == esbt_pkg::OP_CREATE) ? esbt_pkg::ST_NO_FREE
                                                   : esbt_pkg::ST_ABSENT;
        end else if (scan_hit) begin
          sw        <= dword;
          sb        <= scan_lsb;
          ae_word   <= ae_rdata;
          res_found <= 1'b1;
          res_eout  <= 12'(scan_pos);
        end else begin
          dword   <= WAW'(scan_rd);
          scan_rd <= scan_rd + WCW'(1);
          dv      <= 1'b1;
        end
      end
      esbt_pkg::S_DWR: tcnt <= tcnt + TIW'(1);
      esbt_pkg::S_MEV: begin
        if (op == esbt_pkg::OP_ADD && present)       res_status <= esbt_pkg::ST_PRESENT;
        else if (op == esbt_pkg::OP_REMOVE && !present) res_status <= esbt_pkg::ST_ABSENT;
      end
      esbt_pkg::S_REPD: begin
        res_alive <= live;
        res_en    <= ae_en_part[sb];
        res_has   <= tok && present;
      end
      esbt_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {13'(live_cnt), res_has, res_en, res_alive, res_found,
                      res_eout, res_status};
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/esbt_checker.sv */
// Port-level checks of the entity slot bitmap table, bound to its top level.
module esbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |-> m_tdata[2:0] == esbt_pkg::ST_OK)
    else $error("slot found with a failing status");

  a_found_alive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |-> m_tdata[16])
    else $error("found slot is not alive");

  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[15] |-> m_tdata[14:3] == 12'd0)
    else $error("slot reported without found");

endmodule

bind entity_slot_bitmap_table_unit esbt_checker u_esbt_checker (.*);
